>>> rtl/cbf_pkg.sv
// Shared types and constants for the cascading bin fill core.
// Used by the top level; no dependencies.
package cbf_pkg;

	localparam int DEF_MAX_BINS    = 1024;
	localparam int DEF_VALUE_WIDTH = 32;

	localparam int OPCODE_W    = 2;
	localparam int BIN_INDEX_W = 10;
	localparam int AMOUNT_W    = 32;
	localparam int LEVEL_W     = 32;
	localparam int BIN_COUNT_W = 11;

	localparam logic [BIN_COUNT_W-1:0] BIN_COUNT_RESET = 11'd1024;

	localparam int S_TDATA_W = 48;
	localparam int M_TDATA_W = 32;

	typedef enum logic [OPCODE_W-1:0] {
		OP_LOAD  = 2'd0,
		OP_POUR  = 2'd1,
		OP_QUERY = 2'd2
	} opcode_t;

	typedef enum logic [4:0] {
		ST_CLEAR = 5'b00001,
		ST_IDLE  = 5'b00010,
		ST_QRY   = 5'b00100,
		ST_PDAT  = 5'b01000,
		ST_PCMP  = 5'b10000
	} state_t;

endpackage

>>> rtl/cascading_bin_fill_core.sv
// Cascading bin fill: a row of bins with capacity, level and full mark in RAM.
// A query reads the level RAM into its read register, then loads the output register,
// which waits while an earlier result is still waiting. In a pour, each bin that is not
// full is a RAM read followed by an add and a compare-subtract; a full bin is read and
// skipped. Reset (arst_n low) clears control state, then a clear pass zeroes the level
// RAM; no word is accepted during it. Depends on cbf_pkg and cbf_ram.
module cascading_bin_fill_core #(
	parameter int MAX_BINS    = cbf_pkg::DEF_MAX_BINS,
	parameter int VALUE_WIDTH = cbf_pkg::DEF_VALUE_WIDTH
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// [1:0] opcode, [11:2] bin_index, [43:12] amount, [47:44] zero
	input  logic [cbf_pkg::S_TDATA_W-1:0]     s_tdata,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// [31:0] level
	output logic [cbf_pkg::M_TDATA_W-1:0]     m_tdata,
	input  logic                              cfg_we,
	input  logic [cbf_pkg::BIN_COUNT_W-1:0]   cfg_wdata
);

	import cbf_pkg::*;

	localparam int IW    = $clog2(MAX_BINS);
	localparam int CNT_W = $clog2(MAX_BINS + 1);
	localparam int CMPW  = (CNT_W > BIN_COUNT_W) ? CNT_W : BIN_COUNT_W;
	localparam int VW    = VALUE_WIDTH;

	state_t state_q, state_d;

	logic [BIN_COUNT_W-1:0] bins_q;
	logic [IW-1:0]          clr_q;
	logic [IW-1:0]          bin_q;
	logic [VW-1:0]          qty_q;
	logic [VW:0]            sum_q;
	logic                   qzero_q;
	logic                   m_tvalid_q;
	logic [LEVEL_W-1:0]     level_q;

	// Input word fields
	opcode_t                op_in;
	logic [BIN_INDEX_W-1:0] idx_in;
	logic [VW-1:0]          amt_in;
	logic [CMPW-1:0]        idx_w;
	logic [CMPW-1:0]        limit;
	logic [CMPW-1:0]        next_w;
	logic                   present;
	logic                   accept;

	// RAM ports
	logic          cap_we;
	logic [VW-1:0] cap_rdata;
	logic          lvl_we;
	logic [IW-1:0] lvl_waddr;
	logic [VW:0]   lvl_wdata;
	logic [VW:0]   lvl_rdata;
	logic          rd_en;
	logic [IW-1:0] rd_addr;

	logic [VW+1:0] diff;
	logic          more;

	assign op_in   = opcode_t'(s_tdata[1:0]);
	assign idx_in  = s_tdata[11:2];
	assign amt_in  = VW'(s_tdata[43:12]);
	assign idx_w   = CMPW'(idx_in);
	assign present = idx_w < CMPW'(MAX_BINS);
	assign limit   = (CMPW'(bins_q) > CMPW'(MAX_BINS)) ? CMPW'(MAX_BINS) : CMPW'(bins_q);
	assign next_w  = CMPW'(bin_q) + CMPW'(1);
	assign more    = next_w < limit;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	// Level is never above capacity, so spill is level + qty - capacity when not negative.
	assign diff = {1'b0, sum_q} - {2'b00, cap_rdata};

	always_comb begin
		state_d   = state_q;
		cap_we    = 1'b0;
		lvl_we    = 1'b0;
		lvl_waddr = bin_q;
		lvl_wdata = '0;
		rd_en     = 1'b0;
		rd_addr   = next_w[IW-1:0];
		unique case (state_q)
			ST_CLEAR: begin
				lvl_we    = 1'b1;
				lvl_waddr = clr_q;
				if (clr_q == IW'(MAX_BINS - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				rd_addr   = idx_w[IW-1:0];
				lvl_waddr = idx_w[IW-1:0];
				if (accept) begin
					case (op_in)
						OP_LOAD: begin
							cap_we = present;
							lvl_we = present;
						end
						OP_POUR: begin
							if (idx_w < limit && amt_in != '0) begin
								rd_en   = 1'b1;
								state_d = ST_PDAT;
							end
						end
						OP_QUERY: begin
							rd_en   = present;
							state_d = ST_QRY;
						end
						default: ;
					endcase
				end
			end
			ST_QRY: begin
				if (!m_tvalid_q || m_tready) begin
					state_d = ST_IDLE;
				end
			end
			ST_PDAT: begin
				if (lvl_rdata[VW]) begin
					if (more) begin
						rd_en = 1'b1;
					end else begin
						state_d = ST_IDLE;
					end
				end else begin
					state_d = ST_PCMP;
				end
			end
			ST_PCMP: begin
				lvl_we = 1'b1;
				if (diff[VW+1]) begin
					lvl_wdata = {1'b0, sum_q[VW-1:0]};
					state_d   = ST_IDLE;
				end else begin
					lvl_wdata = {1'b1, cap_rdata};
					if (diff != '0 && more) begin
						rd_en   = 1'b1;
						state_d = ST_PDAT;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_q      <= '0;
			bins_q     <= BIN_COUNT_RESET;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + IW'(1);
			end
			if (cfg_we) begin
				bins_q <= cfg_wdata;
			end
			if (state_q == ST_QRY && (!m_tvalid_q || m_tready)) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			bin_q   <= idx_w[IW-1:0];
			qty_q   <= amt_in;
			qzero_q <= !present;
		end
		if (state_q == ST_PDAT) begin
			if (lvl_rdata[VW]) begin
				bin_q <= next_w[IW-1:0];
			end else begin
				sum_q <= {1'b0, lvl_rdata[VW-1:0]} + {1'b0, qty_q};
			end
		end
		if (state_q == ST_PCMP && !diff[VW+1]) begin
			qty_q <= diff[VW-1:0];
			bin_q <= next_w[IW-1:0];
		end
		if (state_q == ST_QRY && (!m_tvalid_q || m_tready)) begin
			level_q <= qzero_q ? '0 : LEVEL_W'(lvl_rdata[VW-1:0]);
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = level_q;

	cbf_ram #(
		.WIDTH(VW),
		.DEPTH(MAX_BINS)
	) u_cap_ram (
		.clk  (clk),
		.we   (cap_we),
		.waddr(idx_w[IW-1:0]),
		.wdata(amt_in),
		.re   (rd_en),
		.raddr(rd_addr),
		.rdata(cap_rdata)
	);

	// Each word holds the full mark above the level.
	cbf_ram #(
		.WIDTH(VW + 1),
		.DEPTH(MAX_BINS)
	) u_lvl_ram (
		.clk  (clk),
		.we   (lvl_we),
		.waddr(lvl_waddr),
		.wdata(lvl_wdata),
		.re   (rd_en),
		.raddr(rd_addr),
		.rdata(lvl_rdata)
	);

	// A pour never writes a bin past the bins in use.
	a_pour_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PCMP) |-> (CMPW'(bin_q) < limit))
		else $error("pour wrote a bin past the bins in use");

	// A result only appears after a query read.
	a_result_from_query: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q == ST_QRY))
		else $error("result appeared without a query");

	// No word is taken while the level RAM is being cleared.
	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> !s_tready)
		else $error("input accepted during clear pass");

	// A stalled result keeps its value.
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> $stable(m_tdata))
		else $error("stalled result changed");

endmodule

>>> rtl/cbf_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module cbf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
